// ----- design/u64dec_pkg.sv -----
// Shared types and constants for the 64-bit binary to decimal ASCII converter.
// Used by the controller, the datapath and the top level; depends on nothing.
package u64dec_pkg;

    localparam int VAL_W      = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 5;
    localparam int BIT_W      = 6;

    localparam logic [5:0]       ASCII_ZERO = 6'd48;
    localparam logic [BIT_W-1:0] BIT_LAST   = BIT_W'(VAL_W - 1);

    // Input beat: number to convert and the two-digit padding flag.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             pad_two;
    } t_in;

    // Output beat: one ASCII digit of the conversion.
    typedef struct packed {
        logic [5:0]       digit_char;
        logic [CNT_W-1:0] digit_count;
        logic             last_digit;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic trim_step;
        logic emit_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trim_done;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

// ----- design/u64_to_decimal_ascii_core.sv -----
// Converts an unsigned 64-bit number to decimal ASCII digits, one output
// beat per digit, most significant first. An item takes a load step, 64
// double-dabble shift steps (one input bit each), one trim step per
// stripped leading zero (20 minus the digit count) plus one step that finds
// the first kept digit, and one emit step per emitted digit (1 to 20). The
// stripped and emitted digits always sum to 20. Each output stall met while
// emitting holds the emit step. Each beat carries the total digit count
// and marks the last digit. Zero gives "0"; with pad_two set, a one-digit
// result gets a leading '0'. The input is stalled while an item is in work;
// the final digit may still wait in the output register while the next
// item is taken.
// Top level; depends on u64dec_pkg, u64dec_ctrl and u64dec_datapath.
module u64_to_decimal_ascii_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  u64dec_pkg::t_in      i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output u64dec_pkg::t_out     o_out_data
);
    import u64dec_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    u64dec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Conversion datapath and output register.
    u64dec_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/u64dec_datapath.sv -----
// Datapath of the converter: double-dabble BCD register, leading-zero trim,
// digit counters and the output register. Depends on u64dec_pkg.
module u64dec_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u64dec_pkg::t_in    i_in_data,
    input  u64dec_pkg::t_cmd   i_cmd,
    output u64dec_pkg::t_sts   o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output u64dec_pkg::t_out   o_out_data
);
    import u64dec_pkg::*;

    logic [VAL_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] w_adj;
    logic             r_pad;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_sent;
    logic             r_out_valid;
    t_out             r_out;
    logic [3:0]       w_top;

    assign w_top = r_bcd[BCD_W-1 -: 4];

    // Add three to every BCD digit of five or more before the next shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Trimming stops at the first nonzero digit, at one digit, or at two
    // digits when padding is requested.
    always_comb begin
        o_sts.trim_done = (w_top != 4'd0) || (r_left == CNT_W'(1))
                          || (r_pad && (r_left == CNT_W'(2)));
        o_sts.emit_last = (r_sent == CNT_W'(r_left - CNT_W'(1)));
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // Conversion registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= i_in_data.value;
            r_bcd  <= '0;
            r_pad  <= i_in_data.pad_two;
            r_left <= CNT_W'(NUM_DIGITS);
            r_sent <= '0;
        end else if (i_cmd.conv_step) begin
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VAL_W-1]};
            r_bin <= {r_bin[VAL_W-2:0], 1'b0};
        end else if (i_cmd.trim_step) begin
            r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
            r_left <= CNT_W'(r_left - CNT_W'(1));
        end else if (i_cmd.emit_step) begin
            r_bcd  <= {r_bcd[BCD_W-5:0], 4'd0};
            r_sent <= CNT_W'(r_sent + CNT_W'(1));
        end
    end

    // Output register: loaded with one digit per emit step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step) begin
            r_out.digit_char  <= ASCII_ZERO + {2'b00, w_top};
            r_out.digit_count <= r_left;
            r_out.last_digit  <= o_sts.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- design/u64dec_ctrl.sv -----
// Controller of the converter: sequences load, 64 shift steps, the
// leading-zero trim and digit emission. Depends on u64dec_pkg.
module u64dec_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  u64dec_pkg::t_sts i_sts,
    output u64dec_pkg::t_cmd o_cmd
);
    import u64dec_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [BIT_W-1:0] r_bit;

    // Commands decoded from the current state and the datapath status.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.conv_step = (r_state == S_CONV);
        o_cmd.trim_step = (r_state == S_TRIM) && !i_sts.trim_done;
        o_cmd.emit_step = (r_state == S_EMIT) && i_sts.out_free;
    end

    assign o_in_stall = (r_state != S_IDLE);

    // State and bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_bit <= '0;
                    if (i_in_valid) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bit <= BIT_W'(r_bit + BIT_W'(1));
                    if (r_bit == BIT_LAST) begin
                        r_state <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    if (i_sts.trim_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free && i_sts.emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/u64_to_decimal_ascii_core_test.sv -----
// Self-checking testbench for u64_to_decimal_ascii_core: drives 64-bit numbers and
// compares every ASCII digit beat against a behavioral decimal conversion.
// Depends on u64dec_pkg and the u64_to_decimal_ascii_core RTL only.
module u64_to_decimal_ascii_core_test;
    import u64dec_pkg::*;

    localparam int          RANDOM_ITEMS   = 207;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 150;
    localparam logic [63:0] DEC_BASE       = 64'd10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    // Numbers waiting to be driven and digit beats waiting to arrive.
    t_in  pending_numbers[$];
    t_out expected_digits[$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int in_calm     = 0;
    int out_calm    = 0;

    u64_to_decimal_ascii_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #6 i_clk = ~i_clk;

    // Idle length: mostly zero or short, a few long, and calm stretches with none.
    function automatic int idle_len(inout int calm);
        int pick;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            calm = $urandom_range(10, 30);
            return 0;
        end else if (pick < 50) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Splits a number into decimal digits and queues one expected beat per digit.
    function automatic void predict_digits(input t_in item);
        logic [63:0] rest;
        logic [3:0]  rev [0:19];
        int          n;
        t_out        beat;
        rest = item.value;
        n = 0;
        do begin
            rev[n] = 4'(rest % DEC_BASE);
            n++;
            rest = rest / DEC_BASE;
        end while (rest != 0);
        // A single digit gets a leading zero when padding is asked for.
        if (item.pad_two && n == 1) begin
            rev[1] = 4'd0;
            n = 2;
        end
        for (int k = 0; k < n; k++) begin
            beat.digit_char  = ASCII_ZERO + {2'b00, rev[n - 1 - k]};
            beat.digit_count = CNT_W'(n);
            beat.last_digit  = (k == n - 1);
            expected_digits.push_back(beat);
        end
    endfunction

    function automatic void queue_number(input logic [63:0] value, input logic pad);
        t_in item;
        item.value   = value;
        item.pad_two = pad;
        pending_numbers.push_back(item);
    endfunction

    // Random numbers spread over all digit lengths, with small values favored for padding.
    function automatic logic [63:0] random_number();
        logic [63:0] full;
        int          pick;
        full = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            return full;
        end else if (pick < 5) begin
            return 64'($urandom_range(0, 99));
        end
        return full >> $urandom_range(1, 63);
    endfunction

    // Input driver: predicts on each accepted beat and presents the next number.
    always @(posedge i_clk) begin
        logic next_valid;
        if (i_rst_n) begin
            next_valid = in_valid;
            if (in_valid && !in_stall) begin
                predict_digits(in_data);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_numbers.size() > 0) begin
                    in_data <= pending_numbers.pop_front();
                    next_valid = 1'b1;
                    gap_left = idle_len(in_calm);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Output monitor: checks each accepted digit beat, drives stall, runs the watchdog.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit beat: char %0d count %0d last %0d",
                           out_data.digit_char, out_data.digit_count, out_data.last_digit);
                    mismatches++;
                end else begin
                    want = expected_digits.pop_front();
                    if (out_data.digit_char !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d",
                               want.digit_char, out_data.digit_char);
                        mismatches++;
                    end
                    if (out_data.digit_count !== want.digit_count) begin
                        $error("digit_count: expected %0d, got %0d",
                               want.digit_count, out_data.digit_count);
                        mismatches++;
                    end
                    if (out_data.last_digit !== want.last_digit) begin
                        $error("last_digit: expected %0d, got %0d",
                               want.last_digit, out_data.last_digit);
                        mismatches++;
                    end
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                stall_left = idle_len(out_calm);
            end

            // Any beat in either direction counts as progress.
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Stimulus: directed corner numbers first, then random ones; then drain and report.
    initial begin
        queue_number(64'd0, 1'b0);
        queue_number(64'd0, 1'b1);
        queue_number(64'd1, 1'b1);
        queue_number(64'd7, 1'b0);
        queue_number(64'd9, 1'b1);
        queue_number(64'd9, 1'b0);
        queue_number(64'd10, 1'b1);
        queue_number(64'd10, 1'b0);
        queue_number(64'd99, 1'b1);
        queue_number(64'd100, 1'b1);
        queue_number(64'd123456789, 1'b0);
        queue_number(64'hFFFF_FFFF, 1'b1);
        queue_number(64'h1_0000_0000, 1'b0);
        queue_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        queue_number(64'h8000_0000_0000_0000, 1'b1);
        queue_number(64'd999999999999999999, 1'b0);
        queue_number(64'd1000000000000000000, 1'b1);
        queue_number(64'd9999999999999999999, 1'b0);
        queue_number(64'd10000000000000000000, 1'b1);
        queue_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_number(64'h5555_5555_5555_5555, 1'b1);
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            queue_number(random_number(), 1'($urandom_range(0, 1)));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() > 0 || in_valid || expected_digits.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_digits.size() > 0) begin
            $error("%0d digit beats never arrived", expected_digits.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- u64_to_decimal_ascii_core.f -----
design/u64dec_pkg.sv
design/u64dec_datapath.sv
design/u64dec_ctrl.sv
design/u64_to_decimal_ascii_core.sv
tb/u64_to_decimal_ascii_core_test.sv
